@@ src/der_tlv_header_scanner_unit_assert.svh @@
// ============================================================================
// Assertion macros for the DER TLV header scanner
// Concurrent checks on the clock and active-low reset, empty under synthesis.
// ============================================================================
`ifndef DER_TLV_HEADER_SCANNER_UNIT_ASSERT_SVH
`define DER_TLV_HEADER_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DTS_ASSERT_IMPLY(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// next-cycle implication
`define DTS_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`else

`define DTS_ASSERT_IMPLY(lbl, ck, rstn, ante, cons)
`define DTS_ASSERT_NEXT(lbl, ck, rstn, ante, cons)

`endif

`endif

@@ src/dts_pkg.sv @@
// ============================================================================
// dts_pkg
// Shared types and constants of the DER TLV header scanner.
// ============================================================================
package dts_pkg;

    // word kinds on the output
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    // fault codes
    typedef enum logic [1:0] {
        ERR_TRUNC    = 2'd0,
        ERR_HIGH_TAG = 2'd1,
        ERR_INDEF    = 2'd2,
        ERR_TOO_MANY = 2'd3
    } err_t;

    localparam int VALUE_LEN_W = 64;
    localparam int OUT_TDATA_W = 88;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // identifier octet fields and length octet codes
    localparam logic [4:0] TAG_HIGH_FORM = 5'b11111;
    localparam logic [7:0] LEN_INDEF     = 8'h80;

    // compact result word between the scanner and the output stage
    typedef struct packed {
        kind_t                    kind;
        logic [7:0]               octet;      // identifier or content byte
        logic [VALUE_LEN_W-1:0]   length;
        logic [3:0]               hdr_bytes;
        logic                     last;
        err_t                     err;
    } rec_t;

endpackage

@@ src/dts_front.sv @@
// ============================================================================
// dts_front
// Byte scanner: walks identifier, length and content octets, one per cycle while
// the queue has room, and pushes one compact result word per byte with a result.
// ============================================================================
`include "der_tlv_header_scanner_unit_assert.svh"

module dts_front
    import dts_pkg::*;
#(
    parameter int MAX_LENGTH_OCTETS = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_buffer,
    input  logic       q_full,
    output logic       push,
    output rec_t       rec
);

    localparam int LEN_W = 8 * MAX_LENGTH_OCTETS;
    localparam int CNT_W = $clog2(MAX_LENGTH_OCTETS + 1);

    typedef enum logic [2:0] {
        PH_IDENT     = 3'd0,
        PH_LEN_FIRST = 3'd1,
        PH_LEN_MORE  = 3'd2,
        PH_VALUE     = 3'd3,
        PH_DROP      = 3'd4
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic [7:0]         ident_reg,  ident_next;
    logic [LEN_W-1:0]   len_reg,    len_next;    // length, then bytes left
    logic [CNT_W-1:0]   left_reg,   left_next;
    logic [3:0]         hcnt_reg,   hcnt_next;

    logic               in_acc;
    logic               emit;
    logic               raise;
    err_t               raise_code;
    logic               finish;
    logic [LEN_W-1:0]   fin_len;
    logic [LEN_W-1:0]   len_dec;
    logic [CNT_W-1:0]   left_dec;

    assign in_ready = !q_full;
    assign in_acc   = in_valid && in_ready;
    assign push     = in_acc && emit;
    assign len_dec  = len_reg - LEN_W'(1);
    assign left_dec = left_reg - CNT_W'(1);

    // next state and result word for the byte on the input
    always_comb
    begin
        phase_next = phase_reg;
        ident_next = ident_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        hcnt_next  = hcnt_reg;
        emit       = 1'b0;
        raise      = 1'b0;
        raise_code = ERR_TRUNC;
        finish     = 1'b0;
        fin_len    = '0;
        rec        = '0;

        unique case (phase_reg)
            PH_IDENT:
            begin
                if (data_byte[4:0] == TAG_HIGH_FORM)
                begin
                    raise      = 1'b1;
                    raise_code = ERR_HIGH_TAG;
                end
                else
                begin
                    ident_next = data_byte;
                    hcnt_next  = 4'd1;
                    phase_next = PH_LEN_FIRST;
                    raise      = end_of_buffer;
                end
            end
            PH_LEN_FIRST:
            begin
                hcnt_next = 4'd2;
                if (data_byte == LEN_INDEF)
                begin
                    raise      = 1'b1;
                    raise_code = ERR_INDEF;
                end
                else if (!data_byte[7])
                begin
                    finish  = 1'b1;
                    fin_len = LEN_W'(data_byte);
                end
                else if (data_byte[6:0] > 7'(MAX_LENGTH_OCTETS))
                begin
                    raise      = 1'b1;
                    raise_code = ERR_TOO_MANY;
                end
                else
                begin
                    left_next  = data_byte[CNT_W-1:0];
                    len_next   = '0;
                    phase_next = PH_LEN_MORE;
                    raise      = end_of_buffer;
                end
            end
            PH_LEN_MORE:
            begin
                fin_len   = (len_reg << 8) | LEN_W'(data_byte);
                len_next  = fin_len;
                hcnt_next = hcnt_reg + 4'd1;
                left_next = left_dec;
                if (left_dec == '0)
                    finish = 1'b1;
                else
                    raise = end_of_buffer;
            end
            PH_VALUE:
            begin
                len_next = len_dec;
                if (end_of_buffer && len_dec != '0)
                    raise = 1'b1;
                else
                begin
                    emit         = 1'b1;
                    rec.kind     = KIND_VALUE;
                    rec.octet    = data_byte;
                    rec.last     = (len_dec == '0);
                    if (len_dec == '0)
                        phase_next = PH_IDENT;
                end
            end
            PH_DROP:
            begin
                phase_next = PH_DROP;
            end
            default:
            begin
                phase_next = PH_IDENT;
                ident_next = '0;
                len_next   = '0;
                left_next  = '0;
                hcnt_next  = '0;
            end
        endcase

        // length complete: header word, or truncation if content cannot follow
        if (finish)
        begin
            if (end_of_buffer && fin_len != '0)
                raise = 1'b1;
            else
            begin
                emit          = 1'b1;
                rec.kind      = KIND_HEADER;
                rec.octet     = ident_reg;
                rec.length    = VALUE_LEN_W'(fin_len);
                rec.hdr_bytes = hcnt_next;
                len_next      = fin_len;
                phase_next    = (fin_len != '0) ? PH_VALUE : PH_IDENT;
            end
        end

        // fault word, then drop until end of buffer
        if (raise)
        begin
            emit       = 1'b1;
            rec        = '0;
            rec.kind   = KIND_ERROR;
            rec.err    = raise_code;
            phase_next = PH_DROP;
        end

        // end of buffer restarts the scanner
        if (end_of_buffer)
        begin
            phase_next = PH_IDENT;
            ident_next = '0;
            len_next   = '0;
            left_next  = '0;
            hcnt_next  = '0;
        end
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDENT;
            ident_reg <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            hcnt_reg  <= '0;
        end
        else if (in_acc)
        begin
            phase_reg <= phase_next;
            ident_reg <= ident_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            hcnt_reg  <= hcnt_next;
        end
    end

    `DTS_ASSERT_NEXT(a_eob_restart, clk, rst_n, in_acc && end_of_buffer, phase_reg == PH_IDENT)

endmodule

@@ src/dts_queue.sv @@
// ============================================================================
// dts_queue
// Two-word queue between the scanner and the output stage.
// ============================================================================
`include "der_tlv_header_scanner_unit_assert.svh"

module dts_queue
    import dts_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output rec_t head_rec
);

    rec_t                mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg,  count_next;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_rec = mem[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + Q_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_rec;
    end

    `DTS_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !full)
    `DTS_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, q_valid)
    `DTS_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= Q_CNT_W'(Q_DEPTH))

endmodule

@@ src/dts_back.sv @@
// ============================================================================
// dts_back
// Output stage: unpacks queued words into stream fields, registered.
// ============================================================================
module dts_back
    import dts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  rec_t                   head_rec,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic [1:0]             m_tuser
);

    logic                   valid_reg;
    logic [OUT_TDATA_W-1:0] tdata_reg,  tdata_next;
    logic                   tlast_reg,  tlast_next;
    logic [1:0]             tuser_reg;

    assign pop = q_valid && (!valid_reg || m_tready);

    // field layout from bit 0: class, constructed, tag, length, header size,
    // content byte, fault code, pad
    always_comb
    begin
        tdata_next = '0;
        tlast_next = 1'b0;
        unique case (head_rec.kind)
            KIND_HEADER:
            begin
                tdata_next[1:0]  = head_rec.octet[7:6];
                tdata_next[2]    = head_rec.octet[5];
                tdata_next[7:3]  = head_rec.octet[4:0];
                tdata_next[71:8] = head_rec.length;
                tdata_next[75:72] = head_rec.hdr_bytes;
            end
            KIND_VALUE:
            begin
                tdata_next[83:76] = head_rec.octet;
                tlast_next        = head_rec.last;
            end
            KIND_ERROR:
            begin
                tdata_next[85:84] = head_rec.err;
            end
            default:
            begin
                tdata_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tdata_reg <= tdata_next;
            tlast_reg <= tlast_next;
            tuser_reg <= head_rec.kind;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

endmodule

@@ src/der_tlv_header_scanner_unit.sv @@
// A taken byte's word is queued, then loaded into the output register when free.
// Throughput: one byte per cycle while the queue is not full, result or not.
// Back-pressure fills the two-word queue and output register before
// s_axis_tready drops, set by the queue fill level.
// Reset (rst_n low, asynchronous) returns the scanner to the identifier
// octet and empties the queue and output register.
// ============================================================================
// der_tlv_header_scanner_unit
// Streaming ASN.1 DER TLV header scanner: header records, content bytes,
// fault words.
// ============================================================================
module der_tlv_header_scanner_unit
    import dts_pkg::*;
#(
    parameter int MAX_LENGTH_OCTETS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // data_byte
    input  logic                   s_axis_tlast,   // end_of_buffer
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // id class[1:0], constructed[2], id number[7:3], content length[71:8],
    // header_bytes[75:72], value_byte[83:76], error_code[85:84], zero[87:86]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,   // last_of_value
    output logic [1:0]             m_axis_tuser    // kind
);

    logic q_full;
    logic push;
    rec_t push_rec;
    logic pop;
    logic q_valid;
    rec_t head_rec;

    dts_front #(
        .MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .data_byte     (s_axis_tdata),
        .end_of_buffer (s_axis_tlast),
        .q_full        (q_full),
        .push          (push),
        .rec           (push_rec)
    );

    dts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head_rec (head_rec)
    );

    dts_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .head_rec (head_rec),
        .pop      (pop),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast),
        .m_tuser  (m_axis_tuser)
    );

endmodule
